// ===== design/ppid_pkg.sv =====
// ----------------------------------------------------------------------------
// Position PID package
// Widths, register indexes, reset values and loop constants shared by the
// position PID controller and its checker.
// ----------------------------------------------------------------------------
package ppid_pkg;

    localparam int POS_W    = 32;
    localparam int GAIN_W   = 16;
    localparam int OUTLIM_W = 16;
    localparam int ILIM_W   = 17;
    localparam int INTEG_W  = 18;
    localparam int DRIVE_W  = 29;
    localparam int FRAC_W   = 12;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_SETPOINT   = 3'd0;
    localparam cfg_index_t REG_GAIN_P     = 3'd1;
    localparam cfg_index_t REG_GAIN_I     = 3'd2;
    localparam cfg_index_t REG_GAIN_D     = 3'd3;
    localparam cfg_index_t REG_MAX_OUTPUT = 3'd4;
    localparam cfg_index_t REG_MIN_OUTPUT = 3'd5;
    localparam cfg_index_t REG_INTEG_LIM  = 3'd6;

    localparam logic signed [POS_W-1:0] SETPOINT_RST   = 32'sd6600;
    localparam logic [GAIN_W-1:0]       GAIN_P_RST     = 16'd4198;
    localparam logic [GAIN_W-1:0]       GAIN_I_RST     = 16'd881;
    localparam logic [GAIN_W-1:0]       GAIN_D_RST     = 16'd410;
    localparam logic [OUTLIM_W-1:0]     MAX_OUTPUT_RST = 16'd500;
    localparam logic [OUTLIM_W-1:0]     MIN_OUTPUT_RST = 16'd50;
    localparam logic [ILIM_W-1:0]       INTEG_LIM_RST  = 17'd66000;

    localparam logic signed [POS_W-1:0] DEADBAND    = 32'sd50;
    localparam logic signed [POS_W-1:0] INTEG_ZONE  = 32'sd400;

endpackage

// ===== design/position_pid_with_deadband.sv =====
// ----------------------------------------------------------------------------
// Position PID controller with deadband
// Per-sample PID loop with error deadband, integral zone and clamp, output saturation
// and a minimum drive magnitude, pipelined at one sample a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the s_ channel carries one measured position (signed
// encoder counts). Each transfer on the m_ channel carries one drive value,
// signed Q.12 in hundredths, in the low 29 bits of m_tdata.
// The cfg_ channel writes one register per transfer: 0 setpoint, 1 gain_p,
// 2 gain_i, 3 gain_d, 4 max_output, 5 min_output, 6 integral_limit. Other
// indexes are ignored. Write registers only while the block is idle; the
// block itself does not enforce this. One sample is accepted every cycle
// while the receiver takes results; the five pipeline stages (input register,
// error, integral and derivative, products, sum and clamp) each hold one sample.
// The integral and the previous error update in the integral stage, so
// consecutive samples see each other's state without a stall.
// When the receiver stalls, the result holds in the output register and
// empty stages keep filling; s_tready falls once every stage is full.
// Reset clears all stages, the integral and the previous error, and loads
// the default register values.
// ----------------------------------------------------------------------------
module position_pid_with_deadband (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ppid_pkg::S_TDATA_W-1:0]     s_tdata,   // [31:0] position
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ppid_pkg::M_TDATA_W-1:0]     m_tdata,   // [28:0] drive, [31:29] zero
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppid_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import ppid_pkg::*;

    logic signed [POS_W-1:0]    setpoint_reg;
    logic [GAIN_W-1:0]          gain_p_reg;
    logic [GAIN_W-1:0]          gain_i_reg;
    logic [GAIN_W-1:0]          gain_d_reg;
    logic [OUTLIM_W-1:0]        max_output_reg;
    logic [OUTLIM_W-1:0]        min_output_reg;
    logic [ILIM_W-1:0]          integ_lim_reg;

    logic                       v0_reg, v1_reg, v2_reg, v3_reg, out_v_reg;
    logic                       en0, en1, en2, en3, en4;

    logic signed [POS_W-1:0]    pos_reg;
    logic signed [POS_W-1:0]    err1_reg, err1_next;
    logic signed [POS_W:0]      diff;

    logic signed [INTEG_W-1:0]  integ_reg, integ_next;
    logic signed [POS_W-1:0]    prev_err_reg;
    logic signed [INTEG_W:0]    integ_sum;
    logic signed [INTEG_W:0]    lim_pos;
    logic signed [INTEG_W:0]    lim_neg;
    logic signed [POS_W-1:0]    err2_reg;
    logic signed [POS_W:0]      derr2_reg, derr_next;
    logic                       nz2_reg, nz3_reg;

    logic signed [48:0]         prod_p_reg, prod_p_next;
    logic signed [34:0]         prod_i_reg, prod_i_next;
    logic signed [49:0]         prod_d_reg, prod_d_next;

    logic signed [51:0]         acc;
    logic signed [51:0]         hi_pos;
    logic signed [51:0]         hi_neg;
    logic signed [DRIVE_W-1:0]  sat;
    logic signed [DRIVE_W-1:0]  lo_pos;
    logic signed [DRIVE_W-1:0]  drive_reg, drive_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg   <= SETPOINT_RST;
            gain_p_reg     <= GAIN_P_RST;
            gain_i_reg     <= GAIN_I_RST;
            gain_d_reg     <= GAIN_D_RST;
            max_output_reg <= MAX_OUTPUT_RST;
            min_output_reg <= MIN_OUTPUT_RST;
            integ_lim_reg  <= INTEG_LIM_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SETPOINT:   setpoint_reg   <= $signed(cfg_data[POS_W-1:0]);
                REG_GAIN_P:     gain_p_reg     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:     gain_i_reg     <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:     gain_d_reg     <= cfg_data[GAIN_W-1:0];
                REG_MAX_OUTPUT: max_output_reg <= cfg_data[OUTLIM_W-1:0];
                REG_MIN_OUTPUT: min_output_reg <= cfg_data[OUTLIM_W-1:0];
                REG_INTEG_LIM:  integ_lim_reg  <= cfg_data[ILIM_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    assign en4      = !out_v_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign en0      = !v0_reg || en1;
    assign s_tready = en0;

    // Error, saturated to 32 bits and zeroed inside the deadband.
    always_comb begin
        diff = {setpoint_reg[POS_W-1], setpoint_reg} - {pos_reg[POS_W-1], pos_reg};
        if (diff[POS_W] != diff[POS_W-1]) begin
            err1_next = diff[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            err1_next = diff[POS_W-1:0];
        end
        if (err1_next < DEADBAND && err1_next > -DEADBAND) begin
            err1_next = '0;
        end
    end

    // Integral inside the zone with symmetric clamp, and the derivative.
    always_comb begin
        lim_pos   = $signed({2'b00, integ_lim_reg});
        lim_neg   = -lim_pos;
        integ_sum = {integ_reg[INTEG_W-1], integ_reg} + err1_reg[INTEG_W:0];
        integ_next = integ_reg;
        if (err1_reg < INTEG_ZONE && err1_reg > -INTEG_ZONE) begin
            if (integ_sum <= lim_neg) begin
                integ_next = lim_neg[INTEG_W-1:0];
            end else if (integ_sum >= lim_pos) begin
                integ_next = lim_pos[INTEG_W-1:0];
            end else begin
                integ_next = integ_sum[INTEG_W-1:0];
            end
        end
        derr_next = {err1_reg[POS_W-1], err1_reg} - {prev_err_reg[POS_W-1], prev_err_reg};
    end

    always_comb begin
        prod_p_next = $signed({33'd0, gain_p_reg})
                    * $signed({{17{err2_reg[POS_W-1]}}, err2_reg});
        prod_i_next = $signed({19'd0, gain_i_reg})
                    * $signed({{17{integ_reg[INTEG_W-1]}}, integ_reg});
        prod_d_next = $signed({34'd0, gain_d_reg})
                    * $signed({{17{derr2_reg[POS_W]}}, derr2_reg});
    end

    // Sum, saturation at max_output and the raise to min_output.
    always_comb begin
        acc = {{3{prod_p_reg[48]}}, prod_p_reg}
            + {{17{prod_i_reg[34]}}, prod_i_reg}
            + {{2{prod_d_reg[49]}}, prod_d_reg};
        hi_pos = $signed({24'd0, max_output_reg, 12'd0});
        hi_neg = -hi_pos;
        if (acc > hi_pos) begin
            sat = hi_pos[DRIVE_W-1:0];
        end else if (acc < hi_neg) begin
            sat = hi_neg[DRIVE_W-1:0];
        end else begin
            sat = acc[DRIVE_W-1:0];
        end
        lo_pos     = $signed({1'b0, min_output_reg, 12'd0});
        drive_next = sat;
        if (nz3_reg) begin
            if (sat > 0 && sat < lo_pos) begin
                drive_next = lo_pos;
            end else if (sat < 0 && sat > -lo_pos) begin
                drive_next = -lo_pos;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            out_v_reg    <= 1'b0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end else begin
            if (en0) begin
                v0_reg <= s_tvalid;
            end
            if (en1) begin
                v1_reg <= v0_reg;
            end
            if (en2) begin
                v2_reg <= v1_reg;
                if (v1_reg) begin
                    integ_reg    <= integ_next;
                    prev_err_reg <= err1_reg;
                end
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en4) begin
                out_v_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en0 && s_tvalid) begin
            pos_reg <= $signed(s_tdata[POS_W-1:0]);
        end
        if (en1) begin
            err1_reg <= err1_next;
        end
        if (en2) begin
            err2_reg  <= err1_reg;
            derr2_reg <= derr_next;
            nz2_reg   <= (err1_reg != 0);
        end
        if (en3) begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
            nz3_reg    <= nz2_reg;
        end
        if (en4) begin
            drive_reg <= drive_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(M_TDATA_W-DRIVE_W){1'b0}}, drive_reg};

endmodule

// ===== design/ppid_checker.sv =====
// ----------------------------------------------------------------------------
// Position PID port checker
// Port-level checks of the position PID controller, bound to its top level.
// ----------------------------------------------------------------------------
module ppid_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [ppid_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [ppid_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppid_pkg::CFG_DAT_W-1:0]     cfg_data
);
    import ppid_pkg::*;

    logic unused_ok;
    assign unused_ok = s_tvalid ^ (^s_tdata) ^ cfg_valid ^ cfg_ready ^ (^cfg_index) ^ (^cfg_data);

    // A result that waits for the receiver keeps its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // No result is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The padding bits above the drive field stay zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:DRIVE_W] == '0)
        else $error("result padding not zero");

    // A ready receiver never blocks the input side.
    a_no_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while receiver ready");

endmodule

bind position_pid_with_deadband ppid_checker u_ppid_checker (.*);
